>>> sv/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// shared types, constants and fixed-point helpers of the expression evaluator
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int FRACTION_BITS = 32;
    localparam int WEIGHT_DEPTH  = 16;
    localparam int MUL_STEPS     = 64;
    localparam int DIV_STEPS     = 128;

    localparam logic [63:0] Q_ONE    = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    // ascii codes
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // operator kind, low two bits of the pending operator
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_MUL   = 2'd2;
    localparam logic [1:0] OP_DIV   = 2'd3;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_POINT,
        CLS_ADDSUB,
        CLS_MULDIV
    } t_cls;

    typedef struct packed {
        t_cls              cls;
        logic              alt;     // minus for add/sub, divide for mul/div
        logic signed [8:0] digit;
        logic              last;
    } t_cmd;

    typedef logic [63:0] t_wtab [WEIGHT_DEPTH];

    // fraction weight for the k-th fraction digit
    function automatic t_wtab f_weights();
        t_wtab       tab;
        logic [63:0] w;
        w = (Q_ONE + 64'd5) / 64'd10;
        for (int k = 0; k < WEIGHT_DEPTH; k++) begin
            tab[k] = w;
            w = (w + 64'd5) / 64'd10;
        end
        return tab;
    endfunction

    localparam t_wtab WEIGHTS = f_weights();

    function automatic logic [63:0] f_mag(input logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic [63:0] f_signed_sat(input logic neg, input logic hi_nz,
                                                 input logic [63:0] lo);
        logic [63:0] r;
        if (neg) begin
            r = (hi_nz || lo > SIGN_MIN) ? SIGN_MIN : (~lo + 64'd1);
        end else begin
            r = (hi_nz || lo[63]) ? POS_MAX : lo;
        end
        return r;
    endfunction

    function automatic logic [63:0] f_sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                                 input logic sub);
        logic [63:0] r;
        logic        ovf;
        r   = sub ? (a - b) : (a + b);
        ovf = sub ? ((a[63] ^ b[63]) && (r[63] ^ a[63]))
                  : (!(a[63] ^ b[63]) && (r[63] ^ a[63]));
        return ovf ? (a[63] ? SIGN_MIN : POS_MAX) : r;
    endfunction

    // x * 10 with saturation
    function automatic logic [63:0] f_mul10(input logic [63:0] x);
        logic [63:0] m;
        logic [67:0] p;
        m = f_mag(x);
        p = ({4'd0, m} << 3) + ({4'd0, m} << 1);
        return f_signed_sat(x[63], |p[67:64], p[63:0]);
    endfunction

endpackage

>>> sv/iee_in_if.sv
// ----------------------------------------------------------------------------
// iee_in_if
// character channel of the expression evaluator
// ----------------------------------------------------------------------------
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> sv/iee_out_if.sv
// ----------------------------------------------------------------------------
// iee_out_if
// result channel of the expression evaluator
// ----------------------------------------------------------------------------
interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic               divide_by_zero;

    modport source (output valid, output value, output divide_by_zero, input ready);
    modport sink   (input valid, input value, input divide_by_zero, output ready);
endinterface

>>> sv/iee_front.sv
// ----------------------------------------------------------------------------
// iee_front
// classifies incoming characters into commands for the queue
// ----------------------------------------------------------------------------
module iee_front (
    iee_in_if.sink           i_in,
    input  logic             i_q_ready,
    output logic             o_q_valid,
    output iee_pkg::t_cmd    o_q_cmd
);
    import iee_pkg::*;

    t_cmd w_cmd;

    always_comb begin
        w_cmd.digit = 9'($signed({1'b0, i_in.char_code}) - $signed({1'b0, CH_ZERO}));
        w_cmd.last  = i_in.last_char;
        w_cmd.alt   = 1'b0;
        unique case (i_in.char_code)
            CH_POINT: w_cmd.cls = CLS_POINT;
            CH_PLUS:  w_cmd.cls = CLS_ADDSUB;
            CH_MINUS: begin
                w_cmd.cls = CLS_ADDSUB;
                w_cmd.alt = 1'b1;
            end
            CH_STAR:  w_cmd.cls = CLS_MULDIV;
            CH_SLASH: begin
                w_cmd.cls = CLS_MULDIV;
                w_cmd.alt = 1'b1;
            end
            default:  w_cmd.cls = CLS_DIGIT;
        endcase
    end

    assign i_in.ready = i_q_ready;
    assign o_q_valid  = i_in.valid;
    assign o_q_cmd    = w_cmd;
endmodule

>>> sv/iee_queue.sv
// ----------------------------------------------------------------------------
// iee_queue
// four-entry command queue between front and back
// ----------------------------------------------------------------------------
module iee_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  iee_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output iee_pkg::t_cmd o_cmd
);
    import iee_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end
endmodule

>>> sv/iee_back.sv
// ----------------------------------------------------------------------------
// iee_back
// executes commands: number building, iterative multiply and divide, sums
// ----------------------------------------------------------------------------
module iee_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  iee_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    iee_out_if.source     o_out
);
    import iee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL10, S_ADD, S_FACTOR, S_MUL, S_DIV, S_SAT, S_POST, S_TERM, S_OUT
    } t_state;

    t_state       r_state,   n_state;
    logic [63:0]  r_sum,     n_sum;
    logic [63:0]  r_prod,    n_prod;
    logic [63:0]  r_cur,     n_cur;
    logic [2:0]   r_op,      n_op;
    logic         r_frac,    n_frac;
    logic [3:0]   r_widx,    n_widx;
    logic         r_zds,     n_zds;
    t_cmd         r_cmd,     n_cmd;
    logic         r_closing, n_closing;
    logic [63:0]  r_addend,  n_addend;
    logic [127:0] r_acc,     n_acc;
    logic [63:0]  r_opa,     n_opa;
    logic [63:0]  r_mb,      n_mb;
    logic [63:0]  r_rem,     n_rem;
    logic         r_neg,     n_neg;
    logic         r_isdiv,   n_isdiv;
    logic [6:0]   r_cnt,     n_cnt;
    logic [63:0]  r_value,   n_value;
    logic         r_dz,      n_dz;
    logic         r_ovalid,  n_ovalid;

    logic [64:0]  w_msum;
    logic [64:0]  w_t;
    logic         w_ge;
    logic [72:0]  w_fprod;
    logic [63:0]  w_newsum;
    logic         w_hi_nz;
    logic [63:0]  w_lo;

    always_comb begin
        w_msum   = {1'b0, r_acc[127:64]} + (r_mb[0] ? {1'b0, r_opa} : 65'd0);
        w_t      = {r_rem, r_acc[127]};
        w_ge     = (w_t >= {1'b0, r_mb});
        w_fprod  = 73'($signed(i_q_cmd.digit) * $signed({1'b0, WEIGHTS[r_widx]}));
        w_newsum = f_sat_addsub(r_sum, r_prod, r_op[2]);
        if (r_isdiv) begin
            w_hi_nz = |r_acc[127:64];
            w_lo    = r_acc[63:0];
        end else begin
            w_hi_nz = |r_acc[127:64+FRACTION_BITS];
            w_lo    = r_acc[63+FRACTION_BITS:FRACTION_BITS];
        end
    end

    always_comb begin
        n_state = r_state;  n_sum = r_sum;     n_prod = r_prod;   n_cur = r_cur;
        n_op = r_op;        n_frac = r_frac;   n_widx = r_widx;   n_zds = r_zds;
        n_cmd = r_cmd;      n_closing = r_closing;                n_addend = r_addend;
        n_acc = r_acc;      n_opa = r_opa;     n_mb = r_mb;       n_rem = r_rem;
        n_neg = r_neg;      n_isdiv = r_isdiv; n_cnt = r_cnt;     n_value = r_value;
        n_dz = r_dz;        n_ovalid = r_ovalid;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    case (i_q_cmd.cls)
                        CLS_POINT: begin
                            n_frac = 1'b1;
                            n_widx = 4'd0;
                            if (i_q_cmd.last) begin
                                n_closing = 1'b1;
                                n_state   = S_FACTOR;
                            end
                        end
                        CLS_DIGIT: begin
                            if (r_frac) begin
                                n_addend = w_fprod[63:0];
                                n_widx   = (r_widx == 4'(WEIGHT_DEPTH - 1)) ? r_widx
                                                                           : r_widx + 4'd1;
                                n_state  = S_ADD;
                            end else begin
                                n_addend = 64'($signed(i_q_cmd.digit)) <<< FRACTION_BITS;
                                n_state  = S_MUL10;
                            end
                        end
                        default: n_state = S_FACTOR;
                    endcase
                end
            end
            S_MUL10: begin
                n_cur   = f_mul10(r_cur);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_cur = f_sat_addsub(r_cur, r_addend, 1'b0);
                if (r_cmd.last) begin
                    n_closing = 1'b1;
                    n_state   = S_FACTOR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FACTOR: begin
                n_neg = r_prod[63] ^ r_cur[63];
                n_mb  = f_mag(r_cur);
                n_cnt = 7'd0;
                if (r_op[1:0] == OP_DIV) begin
                    if (r_cur == 64'd0) begin
                        n_zds   = 1'b1;
                        n_state = S_POST;
                    end else begin
                        n_isdiv = 1'b1;
                        n_acc   = {64'd0, f_mag(r_prod)} << FRACTION_BITS;
                        n_rem   = 64'd0;
                        n_state = S_DIV;
                    end
                end else begin
                    n_isdiv = 1'b0;
                    n_acc   = 128'd0;
                    n_opa   = f_mag(r_prod);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = {w_msum, r_acc[63:1]};
                n_mb  = r_mb >> 1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(MUL_STEPS - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? 64'(w_t - {1'b0, r_mb}) : w_t[63:0];
                n_acc = {r_acc[126:0], w_ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(DIV_STEPS - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_prod  = f_signed_sat(r_neg, w_hi_nz, w_lo);
                n_state = S_POST;
            end
            S_POST: begin
                if (r_closing || r_cmd.cls == CLS_ADDSUB) begin
                    n_state = S_TERM;
                end else begin
                    n_op   = {r_op[2], r_cmd.alt ? OP_DIV : OP_MUL};
                    n_cur  = 64'd0;
                    n_frac = 1'b0;
                    if (r_cmd.last) begin
                        n_closing = 1'b1;
                        n_state   = S_FACTOR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TERM: begin
                n_sum = w_newsum;
                if (r_closing) begin
                    n_value  = r_zds ? 64'd0 : w_newsum;
                    n_dz     = r_zds;
                    n_ovalid = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_op   = {r_cmd.alt, OP_START};
                    n_cur  = 64'd0;
                    n_prod = Q_ONE;
                    n_frac = 1'b0;
                    if (r_cmd.last) begin
                        n_closing = 1'b1;
                        n_state   = S_FACTOR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_ovalid  = 1'b0;
                    n_sum     = 64'd0;
                    n_prod    = Q_ONE;
                    n_cur     = 64'd0;
                    n_op      = {1'b0, OP_START};
                    n_frac    = 1'b0;
                    n_widx    = 4'd0;
                    n_zds     = 1'b0;
                    n_closing = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_addend <= n_addend;
        r_acc    <= n_acc;
        r_opa    <= n_opa;
        r_mb     <= n_mb;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
        r_isdiv  <= n_isdiv;
        r_cnt    <= n_cnt;
        r_value  <= n_value;
        r_dz     <= n_dz;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= 64'd0;
            r_prod    <= Q_ONE;
            r_cur     <= 64'd0;
            r_op      <= {1'b0, OP_START};
            r_frac    <= 1'b0;
            r_widx    <= 4'd0;
            r_zds     <= 1'b0;
            r_closing <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_prod    <= n_prod;
            r_cur     <= n_cur;
            r_op      <= n_op;
            r_frac    <= n_frac;
            r_widx    <= n_widx;
            r_zds     <= n_zds;
            r_closing <= n_closing;
            r_ovalid  <= n_ovalid;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.value          = r_value;
    assign o_out.divide_by_zero = r_dz;
endmodule

>>> sv/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// character-serial evaluator of + - * / expressions in signed Q31.32
// ----------------------------------------------------------------------------
//  channel   dir   transaction
//  i_in      in    one character (char_code) with its last_char mark
//  o_out     out   value and divide_by_zero, once per expression
//
//  a digit runs through S_MUL10 and S_ADD in the back end, a fraction digit
//  through S_ADD only; a point is taken in S_IDLE; an operator closes the
//  open factor: S_FACTOR, the radix-2 multiplier or the restoring divider,
//  S_SAT and S_POST, plus S_TERM for the sum when the operator is + or -
//  the last character adds one more factor and sum close; the result then
//  waits in the output register while the four-entry queue takes characters
//  until full; synchronous active-low reset returns to an empty expression
// ----------------------------------------------------------------------------
module infix_expression_evaluator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iee_in_if.sink    i_in,
    iee_out_if.source o_out
);
    import iee_pkg::*;

    // front to queue
    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_f_cmd;

    // queue to back
    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_q_cmd;

    // character classification
    iee_front u_front (
        .i_in      (i_in),
        .i_q_ready (w_f_ready),
        .o_q_valid (w_f_valid),
        .o_q_cmd   (w_f_cmd)
    );

    // decoupling queue
    iee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_cmd   (w_f_cmd),
        .o_ready (w_f_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // execution: number building, multiply/divide, running sum, result
    iee_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );
endmodule

>>> dv/tb_infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// drives random and directed character streams into the evaluator and checks
// each expression value and divide-by-zero flag against a local predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;
    import iee_pkg::*;

    localparam int          IDLE_MAX  = 18;
    localparam int          WDOG_MAX  = 40000;
    localparam int          HOLD_LONG = 600;
    localparam logic [63:0] TENTH     = (Q_ONE + 64'd5) / 64'd10;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char;

    typedef struct packed {
        logic [63:0] value;
        logic        dbz;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    iee_in_if  chars_if ();
    iee_out_if answer_if ();

    infix_expression_evaluator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chars_if.sink),
        .o_out   (answer_if.source)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // evaluator state of the predictor
    logic [63:0] ev_sum;
    logic [63:0] ev_term;
    logic [63:0] ev_num;
    logic        ev_neg;
    logic [1:0]  ev_kind;
    logic        ev_frac;
    logic [63:0] ev_weight;
    logic        ev_dbz;

    t_char   char_q[$];
    t_answer answer_q[$];

    int  n_mismatch;
    int  n_answers;
    int  n_chars_sent;
    int  n_dbz;
    int  wdog;
    bit  stim_done;
    bit  hold_req;       // receiver long hold-off request
    bit  drain_req;      // sender pauses until all answers are in

    function automatic logic [63:0] mag64(logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    // clamp an unsigned 128-bit magnitude with sign into 64-bit signed range
    function automatic logic [63:0] clamp128(logic neg, logic [127:0] m);
        if (neg) begin
            if (m > 128'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
            return ~m[63:0] + 64'd1;
        end
        if (m > 128'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        return m[63:0];
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic sub);
        logic signed [64:0] r;
        r = sub ? ($signed({a[63], a}) - $signed({b[63], b}))
                : ($signed({a[63], a}) + $signed({b[63], b}));
        if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (r < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
        return r[63:0];
    endfunction

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        return clamp128(a[63] ^ b[63], p >> FRACTION_BITS);
    endfunction

    function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
        logic [127:0] q;
        q = ({64'd0, mag64(a)} << FRACTION_BITS) / {64'd0, mag64(b)};
        return clamp128(a[63] ^ b[63], q);
    endfunction

    task automatic ev_clear();
        ev_sum    = '0;
        ev_term   = Q_ONE;
        ev_num    = '0;
        ev_neg    = 1'b0;
        ev_kind   = OP_START;
        ev_frac   = 1'b0;
        ev_weight = TENTH;
        ev_dbz    = 1'b0;
    endtask

    task automatic ev_close_factor();
        if (ev_kind == OP_DIV) begin
            if (ev_num == '0) ev_dbz = 1'b1;
            else ev_term = fx_div(ev_term, ev_num);
        end else begin
            ev_term = fx_mul(ev_term, ev_num);
        end
    endtask

    // advance the predictor by one accepted character
    task automatic ev_take(t_char c);
        logic signed [63:0] digit;
        case (c.code)
            CH_POINT: begin
                ev_frac   = 1'b1;
                ev_weight = TENTH;
            end
            CH_PLUS, CH_MINUS: begin
                ev_close_factor();
                ev_sum  = add_sat(ev_sum, ev_term, ev_neg);
                ev_neg  = (c.code == CH_MINUS);
                ev_kind = OP_START;
                ev_num  = '0;
                ev_term = Q_ONE;
                ev_frac = 1'b0;
            end
            CH_STAR, CH_SLASH: begin
                ev_close_factor();
                ev_kind = (c.code == CH_STAR) ? OP_MUL : OP_DIV;
                ev_num  = '0;
                ev_frac = 1'b0;
            end
            default: begin
                digit = $signed({56'd0, c.code}) - 64'sd48;
                if (!ev_frac) begin
                    ev_num = fx_mul(ev_num, 64'd10 << FRACTION_BITS);
                    ev_num = add_sat(ev_num, digit * $signed(Q_ONE), 1'b0);
                end else begin
                    ev_num    = add_sat(ev_num, digit * $signed(ev_weight), 1'b0);
                    ev_weight = (ev_weight + 64'd5) / 64'd10;
                end
            end
        endcase
        if (c.last) begin
            ev_close_factor();
            ev_sum = add_sat(ev_sum, ev_term, ev_neg);
            answer_q.push_back('{value: ev_dbz ? 64'd0 : ev_sum, dbz: ev_dbz});
            ev_clear();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    task automatic push_str(string s);
        for (int k = 0; k < s.len(); k++)
            char_q.push_back('{code: s[k], last: (k == s.len() - 1)});
    endtask

    // well-formed expression with random numbers; some zeros to hit division
    task automatic push_expr();
        int n_terms;
        int n_dig;
        n_terms = $urandom_range(1, 4);
        for (int t = 0; t < n_terms; t++) begin
            if (t > 0) char_q.push_back('{code: rand_op(), last: 1'b0});
            if ($urandom_range(0, 7) == 0) begin
                char_q.push_back('{code: CH_ZERO, last: 1'b0});
            end else begin
                n_dig = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 4);
                for (int d = 0; d < n_dig; d++)
                    char_q.push_back('{code: rand_digit(), last: 1'b0});
                if ($urandom_range(0, 2) == 0) begin
                    char_q.push_back('{code: CH_POINT, last: 1'b0});
                    n_dig = $urandom_range(0, 5);
                    for (int d = 0; d < n_dig; d++)
                        char_q.push_back('{code: rand_digit(), last: 1'b0});
                end
            end
        end
        char_q[$].last = 1'b1;
    endtask

    // noise: any byte, last mark on the final byte
    task automatic push_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            char_q.push_back('{code: 8'($urandom_range(0, 255)), last: (k == n - 1)});
    endtask

    // ------------------------------------------------------------------
    // driver: one character per transaction with random gaps
    // ------------------------------------------------------------------
    int  drv_gap;
    bit  drv_busy;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chars_if.valid     <= 1'b0;
            chars_if.char_code <= '0;
            chars_if.last_char <= 1'b0;
            drv_busy           <= 1'b0;
            drv_gap            <= 0;
        end else begin
            if (chars_if.valid && chars_if.ready) begin
                ev_take('{code: chars_if.char_code, last: chars_if.last_char});
                n_chars_sent <= n_chars_sent + 1;
            end
            if (!drv_busy || (chars_if.valid && chars_if.ready)) begin
                // current transaction done; pick the next or idle
                if (drv_gap > 0) begin
                    chars_if.valid <= 1'b0;
                    drv_busy       <= 1'b0;
                    drv_gap        <= drv_gap - 1;
                end else if (drain_req) begin
                    chars_if.valid <= 1'b0;
                    drv_busy       <= 1'b0;
                end else if (char_q.size() > 0) begin
                    t_char c;
                    c = char_q.pop_front();
                    chars_if.valid     <= 1'b1;
                    chars_if.char_code <= c.code;
                    chars_if.last_char <= c.last;
                    drv_busy           <= 1'b1;
                    // about two thirds of items go back to back
                    drv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
                end else begin
                    chars_if.valid <= 1'b0;
                    drv_busy       <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random ready with a long hold-off on request
    // ------------------------------------------------------------------
    int  mon_stall;
    int  mon_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answer_if.ready <= 1'b0;
            mon_stall       <= 0;
            mon_hold        <= 0;
        end else begin
            if (answer_if.valid && answer_if.ready) begin
                n_answers <= n_answers + 1;
                if (answer_q.size() == 0) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("result with no expression pending: value %0d flag %0b",
                                 answer_if.value, answer_if.divide_by_zero);
                end else begin
                    t_answer exp_a;
                    exp_a = answer_q.pop_front();
                    if (exp_a.dbz) n_dbz <= n_dbz + 1;
                    if (answer_if.value !== exp_a.value
                        || answer_if.divide_by_zero !== exp_a.dbz) begin
                        n_mismatch <= n_mismatch + 1;
                        if (n_mismatch < 10)
                            $display("mismatch: value exp %0d got %0d, flag exp %0b got %0b",
                                     $signed(exp_a.value), answer_if.value,
                                     exp_a.dbz, answer_if.divide_by_zero);
                    end
                end
            end
            if (hold_req && mon_hold == 0) begin
                mon_hold        <= HOLD_LONG;
                answer_if.ready <= 1'b0;
            end else if (mon_hold > 1) begin
                mon_hold        <= mon_hold - 1;
                answer_if.ready <= 1'b0;
            end else if (mon_stall > 0) begin
                mon_stall       <= mon_stall - 1;
                answer_if.ready <= 1'b0;
            end else begin
                answer_if.ready <= 1'b1;
                if (answer_if.valid && answer_if.ready)
                    mon_stall <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
                if (mon_hold == 1) mon_hold <= 0;
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (chars_if.valid && chars_if.ready)
            || (answer_if.valid && answer_if.ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired, %0d results outstanding", answer_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (char_q.size() > 0 || drv_busy || answer_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        n_mismatch   = 0;
        n_answers    = 0;
        n_chars_sent = 0;
        n_dbz        = 0;
        stim_done    = 1'b0;
        hold_req     = 1'b0;
        drain_req    = 1'b0;
        ev_clear();
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, each operator, zero divisors, odd bytes
        push_str("7");
        push_str("12+34");
        push_str("9-25");
        push_str("6*7");
        push_str("1/3");
        push_str("5/0");
        push_str("5*0/0+1");
        push_str("3.25*-2");
        push_str("1.5.25");
        push_str("99999999999+9999999999");
        push_str("-99999999999-9999999999");
        push_str("999999*999999*999");
        push_str("1/0.000000001");
        push_str("0.123456789012345");
        char_q.push_back('{code: 8'hFF, last: 1'b1});
        char_q.push_back('{code: 8'h00, last: 1'b1});
        push_str("+-*/.");
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        for (int k = 0; k < 20; k++) push_expr();
        while (mon_hold == 0) @(posedge i_clk);
        hold_req = 1'b0;
        wait_drained();

        // random phase
        while (n_chars_sent < 800) begin
            if ($urandom_range(0, 4) == 0) push_noise();
            else push_expr();
            if ($urandom_range(0, 60) == 0) begin
                // sender pause until every result is back
                drain_req = 1'b1;
                while (answer_q.size() > 0 || drv_busy) @(posedge i_clk);
                drain_req = 1'b0;
            end
            while (char_q.size() > 8) @(posedge i_clk);
        end
        wait_drained();
        stim_done = 1'b1;
        repeat (300) @(posedge i_clk);

        $display("covered %0d characters, %0d results, %0d with division by zero",
                 n_chars_sent, n_answers, n_dbz);
        if (n_mismatch == 0 && answer_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
